/* rtl/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the substring position search.
// Holds the register map and the control bundle that drives each cell.
// ----------------------------------------------------------------------------
package sps_pkg;

   localparam int ByteW     = 8;
   localparam int PatBytes  = 16;
   localparam int CfgLenW   = 5;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 64;
   localparam int PosW      = 16;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2,
      CSR_FIND_LAST      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             shift;
      logic             active;
      logic [ByteW-1:0] expected;
   } cell_ctrl_type;

endpackage

/* rtl/sps_cell.sv */
// ----------------------------------------------------------------------------
// sps_cell: one window cell of the substring position search.
// Holds one buffer byte, passes it on to its neighbor on every transfer and
// compares the byte it takes in with the pattern byte it is given.
// ----------------------------------------------------------------------------
module sps_cell (
   input  logic                       clock,
   input  sps_pkg::cell_ctrl_type     ctrl,
   input  logic [sps_pkg::ByteW-1:0]  byte_in,
   output logic [sps_pkg::ByteW-1:0]  byte_out,
   output logic                       hit
);
   import sps_pkg::*;

   logic [ByteW-1:0] window_ff;
   logic [ByteW-1:0] window_in;

   assign window_in = ctrl.shift ? byte_in : window_ff;
   assign hit       = !ctrl.active || (window_in == ctrl.expected);
   assign byte_out  = window_ff;

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

/* rtl/substring_position_search.sv */
// ----------------------------------------------------------------------------
// substring_position_search: streaming search for a pattern of up to 16 bytes.
// Throughput is one item per clock unless a closing item meets a held result;
// a closing item's result is in the output register the cycle after transfer.
// The cell chain compares every window position with the pattern in parallel.
// Synchronous reset clears the CSRs, the counters and the result valid only.
// ----------------------------------------------------------------------------
module substring_position_search #(
   parameter int MAX_PATTERN = 16,
   parameter int MAX_BUFFER  = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sps_pkg::ByteW-1:0]     req_data_byte,
   input  logic                          req_byte_present,
   input  logic                          req_buffer_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [sps_pkg::PosW-1:0]      rsp_match_start,
   output logic                          rsp_length_overflow,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sps_pkg::CsrIndexW-1:0] csr_index,
   input  logic [sps_pkg::CsrDataW-1:0]  csr_data
);
   import sps_pkg::*;

   localparam int CntW  = $clog2(MAX_BUFFER + 1);
   localparam int LenW  = ($clog2(MAX_PATTERN + 1) > CfgLenW) ?
                          $clog2(MAX_PATTERN + 1) : CfgLenW;
   localparam int DiffW = (CntW > LenW) ? CntW : LenW;

   logic [CsrDataW-1:0] pat_low_ff;
   logic [CsrDataW-1:0] pat_high_ff;
   logic [CfgLenW-1:0]  pat_len_ff;
   logic                find_last_ff;

   logic [CntW-1:0]     count_ff, count_in;
   logic                match_seen_ff, match_seen_in;
   logic [PosW-1:0]     match_pos_ff, match_pos_in;
   logic                ovf_ff, ovf_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [PosW-1:0]     rsp_start_ff, rsp_start_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic [2*CsrDataW-1:0] pat_vec;
   logic [LenW-1:0]       pat_len_ext;
   logic [LenW-1:0]       used_len;

   logic                  req_fire, close, full, take;
   logic [CntW-1:0]       count_nx;
   logic [DiffW-1:0]      diff;
   logic [PosW-1:0]       diff_clip, count_clip;
   logic                  all_hit, hit_now, upd;
   logic                  match_nx, ovf_nx;
   logic [PosW-1:0]       pos_nx;

   cell_ctrl_type         ctrl   [MAX_PATTERN];
   logic [ByteW-1:0]      chain  [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] hits;

   assign pat_vec     = {pat_high_ff, pat_low_ff};
   assign pat_len_ext = LenW'(pat_len_ff);
   assign used_len    = (pat_len_ext > LenW'(MAX_PATTERN)) ? LenW'(MAX_PATTERN) : pat_len_ext;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall && req_buffer_end;
   assign close     = req_fire && req_buffer_end;
   assign full      = (count_ff >= CntW'(MAX_BUFFER));
   assign take      = req_fire && req_byte_present && !full;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [LenW-1:0] idx;
      assign idx = used_len - LenW'(k + 1);
      assign ctrl[k].shift    = take;
      assign ctrl[k].active   = (LenW'(k) < used_len);
      assign ctrl[k].expected = (idx < LenW'(PatBytes)) ?
                                pat_vec[idx[3:0]*ByteW +: ByteW] : '0;
      if (k == 0) begin : g_head
         sps_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl[k]),
            .byte_in  (req_data_byte),
            .byte_out (chain[k]),
            .hit      (hits[k])
         );
      end else begin : g_body
         sps_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl[k]),
            .byte_in  (chain[k-1]),
            .byte_out (chain[k]),
            .hit      (hits[k])
         );
      end
   end

   assign all_hit  = &hits;
   assign count_nx = take ? (count_ff + CntW'(1)) : count_ff;
   assign diff     = DiffW'(count_nx) - DiffW'(used_len);

   if (DiffW > PosW) begin : g_diff_sat
      assign diff_clip = (diff > DiffW'({PosW{1'b1}})) ? {PosW{1'b1}} : diff[PosW-1:0];
   end else begin : g_diff_ext
      assign diff_clip = PosW'(diff);
   end

   if (CntW > PosW) begin : g_cnt_sat
      assign count_clip = (count_nx > CntW'({PosW{1'b1}})) ? {PosW{1'b1}} : count_nx[PosW-1:0];
   end else begin : g_cnt_ext
      assign count_clip = PosW'(count_nx);
   end

   assign hit_now  = take && (used_len != '0) &&
                     (DiffW'(count_nx) >= DiffW'(used_len)) && all_hit;
   assign upd      = hit_now && (find_last_ff || !match_seen_ff);
   assign match_nx = match_seen_ff || upd;
   assign pos_nx   = upd ? diff_clip : match_pos_ff;
   assign ovf_nx   = ovf_ff || (req_fire && req_byte_present && full);

   always_comb begin
      count_in      = count_nx;
      match_seen_in = match_nx;
      match_pos_in  = pos_nx;
      ovf_in        = ovf_nx;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (close) begin
         count_in      = '0;
         match_seen_in = 1'b0;
         match_pos_in  = '0;
         ovf_in        = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_ovf_in    = ovf_nx;
         if (used_len == '0) begin
            rsp_found_in = 1'b1;
            rsp_start_in = find_last_ff ? count_clip : '0;
         end else begin
            rsp_found_in = match_nx;
            rsp_start_in = match_nx ? pos_nx : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff    <= '0;
         pat_high_ff   <= '0;
         pat_len_ff    <= '0;
         find_last_ff  <= 1'b0;
         count_ff      <= '0;
         match_seen_ff <= 1'b0;
         match_pos_ff  <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         match_seen_ff <= match_seen_in;
         match_pos_ff  <= match_pos_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW:    pat_low_ff   <= csr_data;
               CSR_PATTERN_HIGH:   pat_high_ff  <= csr_data;
               CSR_PATTERN_LENGTH: pat_len_ff   <= csr_data[CfgLenW-1:0];
               CSR_FIND_LAST:      find_last_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_match_start     = rsp_start_ff;
   assign rsp_length_overflow = rsp_ovf_ff;

endmodule

/* rtl/sps_checker.sv */
// ----------------------------------------------------------------------------
// sps_checker: port-level checks of the substring position search.
// Watches the request and result channels and the result fields over time.
// ----------------------------------------------------------------------------
module sps_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_buffer_end,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_found,
   input logic [sps_pkg::PosW-1:0]  rsp_match_start,
   input logic                      rsp_length_overflow
);
   import sps_pkg::*;

   logic req_close;
   assign req_close = req_valid && !req_stall && req_buffer_end;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_match_start) && $stable(rsp_length_overflow))
      else $error("Stalled result changed.");

   a_close_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_close |=> rsp_valid)
      else $error("Closing transfer gave no result.");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_close && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("Result appeared without a closing transfer.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Request stalled while the result path was free.");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_start == '0)
      else $error("Start position is nonzero on a miss.");

endmodule

bind substring_position_search sps_checker u_sps_checker (.*);
